### src/mrta_pkg.sv
// ----------------------------------------------------------------------------
// mrta_pkg
// Shared types and constants of the multicore response time analyser.
// ----------------------------------------------------------------------------
package mrta_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_TASKS          = 16;
  localparam int DEF_MAX_FIXPOINT_ITERS = 256;
  localparam int DEF_MAX_JOBS           = 64;

  // width of the internal time values (iterates, workloads, sums)
  localparam int XW = 34;

  // at most M-1 carry-in gains are kept, M up to 31
  localparam int TOP_SLOTS = 30;

  localparam logic [23:0] RESP_MAX = 24'hFFFFFF;

  localparam logic [4:0] PC_RESET = 5'd2;

  // transaction function codes
  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_APPEND  = 2'd1;
  localparam logic [1:0] FUNC_ANALYZE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_CAP     = 2'd3;

  // one entry of the higher-priority task table
  // st is the carry-in offset plus one, lv the flat level plus one
  typedef struct packed {
    logic [15:0]   c;
    logic [15:0]   t;
    logic [XW-1:0] st;
    logic [XW-1:0] lv;
  } ent_t;

endpackage

### src/mrta_in_if.sv
// ----------------------------------------------------------------------------
// mrta_in_if
// Input channel: valid/ready handshake with one task transaction.
// ----------------------------------------------------------------------------
interface mrta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] exec_time;
  logic [15:0] task_period;
  logic [15:0] response_bound;
  logic [15:0] task_deadline;

  modport source (output valid, func, exec_time, task_period, response_bound,
                  task_deadline, input ready);
  modport sink (input valid, func, exec_time, task_period, response_bound,
                task_deadline, output ready);
endinterface

### src/mrta_out_if.sv
// ----------------------------------------------------------------------------
// mrta_out_if
// Result channel: valid/ready handshake with one analysis result.
// ----------------------------------------------------------------------------
interface mrta_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        schedulable;
  logic [23:0] response_time;

  modport source (output valid, status, schedulable, response_time, input ready);
  modport sink (input valid, status, schedulable, response_time, output ready);
endinterface

### src/mrta_ram.sv
// ----------------------------------------------------------------------------
// mrta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/mrta_div.sv
// ----------------------------------------------------------------------------
// mrta_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module mrta_div #(
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [15:0]   rem
);
  localparam int NW = $clog2(DW + 1);

  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   dvs_r, dvs_nxt;
  logic [16:0]   trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DW-1]};
    if (start) begin
      cnt_nxt = NW'(DW);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

### src/multicore_response_time_analyzer.sv
// ----------------------------------------------------------------------------
// multicore_response_time_analyzer
// Global fixed-priority response time analysis with limited carry-in.
// ----------------------------------------------------------------------------
// Clear and rejected transactions go from the idle state straight to the
// result emit state; an append spends most of its time in the shared 34-bit
// divider that forms the carry-in job count. An analyse transaction walks the
// task table once per fixed-point step: each entry costs up to two serial
// divisions, and each step adds the carry-in gain sum and the division by
// M; this repeats for every step of every job. The single divider works one
// bit per cycle. A new transaction is taken only when the sequencer is idle;
// a finished result may still wait in the output register meanwhile.
module multicore_response_time_analyzer #(
  parameter int MAX_TASKS          = mrta_pkg::DEF_MAX_TASKS,
  parameter int MAX_FIXPOINT_ITERS = mrta_pkg::DEF_MAX_FIXPOINT_ITERS,
  parameter int MAX_JOBS           = mrta_pkg::DEF_MAX_JOBS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  mrta_in_if.sink    in_ch,
  mrta_out_if.source out_ch
);
  import mrta_pkg::*;

  localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int ITW = $clog2(MAX_FIXPOINT_ITERS);
  localparam int HW  = $clog2(MAX_JOBS + 1);
  localparam int KW  = $clog2(TOP_SLOTS);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_APP_DIV  = 17'h00002,
    S_APP_MQT  = 17'h00004,
    S_APP_MQC  = 17'h00008,
    S_IT_START = 17'h00010,
    S_RD       = 17'h00020,
    S_LD       = 17'h00040,
    S_PL_DIV   = 17'h00080,
    S_PL_MUL   = 17'h00100,
    S_CY_CHK   = 17'h00200,
    S_CY_DIV   = 17'h00400,
    S_CY_MUL   = 17'h00800,
    S_ACC      = 17'h01000,
    S_TOP_SUM  = 17'h02000,
    S_M_DIV    = 17'h04000,
    S_CHECK    = 17'h08000,
    S_EMIT     = 17'h10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [4:0]    pc_r, pc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [15:0]   c_r, c_nxt, t_r, t_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [XW-1:0] x_r, x_nxt, hc_r, hc_nxt, offs_r, offs_nxt, cap_r, cap_nxt;
  logic [XW-1:0] sum_r, sum_nxt, pl_r, pl_nxt, cw_r, cw_nxt, st_r, st_nxt;
  logic [XW:0]   worst_r, worst_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [ITW-1:0] it_r, it_nxt;
  logic [HW-1:0] h_r, h_nxt;
  ent_t          ent_r, ent_nxt;
  logic [XW-1:0] top_r [TOP_SLOTS];
  logic [XW-1:0] top_nxt [TOP_SLOTS];
  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_sched_r, res_sched_nxt;
  logic [23:0]   res_resp_r, res_resp_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_sched_r, out_sched_nxt;
  logic [23:0]   out_resp_r, out_resp_nxt;

  // shared multiplier, result registered
  logic [XW-1:0]    mul_a;
  logic [15:0]      mul_b;
  logic [XW+15:0]   prod_r;
  logic [XW-1:0]    prod;

  logic             div_start, div_done;
  logic [XW-1:0]    div_dvd, div_quo;
  logic [15:0]      div_dvs, div_rem;

  logic             ram_we;
  ent_t             ram_wdata, ram_rdata;

  logic [4:0]       m_w, slots_w;
  logic [XW-1:0]    xp1, rem_c, wc, xn;
  logic signed [XW+1:0] gain;
  logic [XW:0]      resp;
  logic             fix_done;

  mrta_div #(.DW(XW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  mrta_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_TASKS)) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end
  assign prod = prod_r[XW-1:0];

  assign m_w     = (pc_r == 5'd0) ? 5'd1 : pc_r;
  assign slots_w = m_w - 5'd1;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.schedulable   = out_sched_r;
  assign out_ch.response_time = out_resp_r;

  assign ram_wdata = '{c: c_r, t: t_r, st: st_r, lv: prod};

  // helpers for the workload and check steps
  assign xp1   = x_r + XW'(1);
  assign rem_c = (div_rem < c_r) ? XW'(div_rem) : XW'(c_r);
  assign wc    = (div_rem < ent_r.c) ? XW'(div_rem) : XW'(ent_r.c);
  assign gain  = $signed({2'b00, cw_r}) - $signed({2'b00, pl_r});
  assign xn    = div_quo + hc_r;
  assign resp  = {1'b0, xn} - {1'b0, offs_r};
  assign fix_done = ($signed(resp) > $signed((XW+1)'(d_r))) || (xn == x_r);

  function automatic logic [23:0] sat24(input logic [XW:0] v);
    if (v > (XW+1)'(RESP_MAX)) begin
      return RESP_MAX;
    end
    return v[23:0];
  endfunction

  always_comb begin
    logic [XW-1:0] w;
    logic [XW:0]   wn;
    state_nxt      = state_r;
    pc_nxt         = cfg_wr_en ? cfg_wr_data : pc_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    c_nxt = c_r;  t_nxt = t_r;  r_nxt = r_r;  d_nxt = d_r;
    x_nxt = x_r;  hc_nxt = hc_r;  offs_nxt = offs_r;  cap_nxt = cap_r;
    sum_nxt = sum_r;  pl_nxt = pl_r;  cw_nxt = cw_r;  st_nxt = st_r;
    worst_nxt = worst_r;  idx_nxt = idx_r;  k_nxt = k_r;
    it_nxt = it_r;  h_nxt = h_r;  ent_nxt = ent_r;
    top_nxt = top_r;
    res_status_nxt = res_status_r;  res_sched_nxt = res_sched_r;
    res_resp_nxt = res_resp_r;
    out_status_nxt = out_status_r;  out_sched_nxt = out_sched_r;
    out_resp_nxt = out_resp_r;
    div_start = 1'b0;  div_dvd = '0;  div_dvs = '0;
    mul_a = '0;  mul_b = '0;
    ram_we = 1'b0;
    w  = '0;
    wn = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          c_nxt = in_ch.exec_time;
          t_nxt = in_ch.task_period;
          r_nxt = in_ch.response_bound;
          d_nxt = in_ch.task_deadline;
          res_status_nxt = ST_OK;
          res_sched_nxt  = 1'b0;
          res_resp_nxt   = '0;
          state_nxt      = S_EMIT;
          case (in_ch.func)
            FUNC_CLEAR: begin
              cnt_nxt = '0;
            end
            FUNC_APPEND: begin
              if (in_ch.exec_time == 16'd0 || in_ch.task_period == 16'd0 ||
                  in_ch.exec_time >= in_ch.task_period ||
                  in_ch.response_bound < in_ch.exec_time) begin
                res_status_nxt = ST_INVALID;
              end else if (32'(cnt_r) >= MAX_TASKS) begin
                res_status_nxt = ST_FULL;
              end else begin
                // ceil((R-C)/(T-C))
                div_start = 1'b1;
                div_dvd   = XW'(in_ch.response_bound) + XW'(in_ch.task_period)
                          - XW'(in_ch.exec_time) - XW'(in_ch.exec_time) - XW'(1);
                div_dvs   = in_ch.task_period - in_ch.exec_time;
                state_nxt = S_APP_DIV;
              end
            end
            FUNC_ANALYZE: begin
              if (in_ch.exec_time == 16'd0 || in_ch.task_period == 16'd0 ||
                  in_ch.task_deadline == 16'd0) begin
                res_status_nxt = ST_INVALID;
              end else if (32'(cnt_r) < 32'(m_w)) begin
                res_sched_nxt = (in_ch.exec_time <= in_ch.task_deadline);
                res_resp_nxt  = 24'(in_ch.exec_time);
              end else begin
                x_nxt     = XW'(in_ch.exec_time);
                hc_nxt    = XW'(in_ch.exec_time);
                offs_nxt  = '0;
                worst_nxt = '0;
                h_nxt     = HW'(1);
                it_nxt    = '0;
                state_nxt = S_IT_START;
              end
            end
            default: begin
              res_status_nxt = ST_INVALID;
            end
          endcase
        end
      end

      S_APP_DIV: begin
        mul_a = div_quo;
        mul_b = t_r;
        if (div_done) begin
          state_nxt = S_APP_MQT;
        end
      end

      S_APP_MQT: begin
        st_nxt    = XW'(c_r) + prod - XW'(r_r);
        mul_a     = div_quo;
        mul_b     = c_r;
        state_nxt = S_APP_MQC;
      end

      S_APP_MQC: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_EMIT;
      end

      S_IT_START: begin
        cap_nxt   = x_r - hc_r + XW'(1);
        sum_nxt   = '0;
        idx_nxt   = '0;
        for (int p = 0; p < TOP_SLOTS; p++) begin
          top_nxt[p] = '0;
        end
        state_nxt = S_RD;
      end

      S_RD: begin
        state_nxt = S_LD;
      end

      S_LD: begin
        ent_nxt   = ram_rdata;
        div_start = 1'b1;
        div_dvd   = x_r;
        div_dvs   = ram_rdata.t;
        state_nxt = S_PL_DIV;
      end

      S_PL_DIV: begin
        mul_a = div_quo;
        mul_b = ent_r.c;
        if (div_done) begin
          state_nxt = S_PL_MUL;
        end
      end

      S_PL_MUL: begin
        w         = prod + wc;
        pl_nxt    = (w < cap_r) ? w : cap_r;
        state_nxt = S_CY_CHK;
      end

      S_CY_CHK: begin
        if (xp1 <= ent_r.lv) begin
          cw_nxt    = (x_r < cap_r) ? x_r : cap_r;
          state_nxt = S_ACC;
        end else if (xp1 < ent_r.st) begin
          w         = ent_r.lv - XW'(1);
          cw_nxt    = (w < cap_r) ? w : cap_r;
          state_nxt = S_ACC;
        end else begin
          div_start = 1'b1;
          div_dvd   = xp1 - ent_r.st;
          div_dvs   = ent_r.t;
          state_nxt = S_CY_DIV;
        end
      end

      S_CY_DIV: begin
        mul_a = div_quo;
        mul_b = ent_r.c;
        if (div_done) begin
          state_nxt = S_CY_MUL;
        end
      end

      S_CY_MUL: begin
        w         = ent_r.lv + prod + wc - XW'(1);
        cw_nxt    = (w < cap_r) ? w : cap_r;
        state_nxt = S_ACC;
      end

      S_ACC: begin
        sum_nxt = sum_r + pl_r;
        // sorted insert into the list of the largest carry-in gains
        if (gain > 0 && slots_w != 5'd0) begin
          for (int p = 0; p < TOP_SLOTS; p++) begin
            if (p < int'(slots_w) && top_r[p] < cw_r - pl_r) begin
              if (p == 0) begin
                top_nxt[p] = cw_r - pl_r;
              end else if (top_r[(p > 0) ? p - 1 : 0] >= cw_r - pl_r) begin
                top_nxt[p] = cw_r - pl_r;
              end else begin
                top_nxt[p] = top_r[(p > 0) ? p - 1 : 0];
              end
            end
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == cnt_r) begin
          k_nxt     = '0;
          state_nxt = S_TOP_SUM;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_TOP_SUM: begin
        sum_nxt = sum_r + top_r[k_r];
        k_nxt   = k_r + 1'b1;
        if (k_r == KW'(TOP_SLOTS - 1)) begin
          div_start = 1'b1;
          div_dvd   = sum_r + top_r[k_r];
          div_dvs   = 16'(m_w);
          state_nxt = S_M_DIV;
        end
      end

      S_M_DIV: begin
        if (div_done) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        wn = ($signed(resp) > $signed(worst_r)) ? resp : worst_r;
        worst_nxt = wn;
        if (!fix_done) begin
          if (it_r == ITW'(MAX_FIXPOINT_ITERS - 1)) begin
            res_status_nxt = ST_CAP;
            res_sched_nxt  = 1'b0;
            res_resp_nxt   = sat24(wn);
            state_nxt      = S_EMIT;
          end else begin
            it_nxt    = it_r + 1'b1;
            x_nxt     = xn;
            state_nxt = S_IT_START;
          end
        end else if ($signed(wn) > $signed((XW+1)'(d_r)) ||
                     $signed(resp) <= $signed((XW+1)'(t_r))) begin
          res_status_nxt = ST_OK;
          res_sched_nxt  = !($signed(wn) > $signed((XW+1)'(d_r)));
          res_resp_nxt   = sat24(wn);
          state_nxt      = S_EMIT;
        end else if (h_r == HW'(MAX_JOBS)) begin
          res_status_nxt = ST_CAP;
          res_sched_nxt  = 1'b0;
          res_resp_nxt   = sat24(wn);
          state_nxt      = S_EMIT;
        end else begin
          // next job of the busy window
          h_nxt     = h_r + 1'b1;
          hc_nxt    = hc_r + XW'(c_r);
          offs_nxt  = offs_r + XW'(t_r);
          x_nxt     = hc_r + XW'(c_r);
          it_nxt    = '0;
          state_nxt = S_IT_START;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_sched_nxt  = res_sched_r;
          out_resp_nxt   = res_resp_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= PC_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;  t_r <= t_nxt;  r_r <= r_nxt;  d_r <= d_nxt;
    x_r <= x_nxt;  hc_r <= hc_nxt;  offs_r <= offs_nxt;  cap_r <= cap_nxt;
    sum_r <= sum_nxt;  pl_r <= pl_nxt;  cw_r <= cw_nxt;  st_r <= st_nxt;
    worst_r <= worst_nxt;  idx_r <= idx_nxt;  k_r <= k_nxt;
    it_r <= it_nxt;  h_r <= h_nxt;  ent_r <= ent_nxt;
    top_r <= top_nxt;
    res_status_r <= res_status_nxt;
    res_sched_r  <= res_sched_nxt;
    res_resp_r   <= res_resp_nxt;
    out_status_r <= out_status_nxt;
    out_sched_r  <= out_sched_nxt;
    out_resp_r   <= out_resp_nxt;
  end
endmodule

### src/mrta_checker.sv
// ----------------------------------------------------------------------------
// mrta_checker
// Port-level checks of the response time analyser, bound to the top level.
// ----------------------------------------------------------------------------
module mrta_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        schedulable,
  input logic [23:0] response_time
);
  import mrta_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(schedulable) && $stable(response_time))
    else $error("stalled result changed");

  a_sched_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && schedulable |-> status == ST_OK)
    else $error("schedulable with bad status");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL || status == ST_INVALID) |->
    response_time == 24'd0)
    else $error("rejected transaction with response time");

  // the sequencer is busy in the cycle after it takes a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");
endmodule

bind multicore_response_time_analyzer mrta_checker u_mrta_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .schedulable   (out_ch.schedulable),
  .response_time (out_ch.response_time)
);

### tb/multicore_response_time_analyzer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicore_response_time_analyzer_tb
// Drives clear, append, analyse and invalid-function transactions with random
// idling on both channels. A scoreboard predicts each result from its own copy
// of the task table and the processor count, and checks the results in order.
// ----------------------------------------------------------------------------
module multicore_response_time_analyzer_tb;
  import mrta_pkg::*;

  localparam int NTASKS   = DEF_MAX_TASKS;
  localparam int NITERS   = DEF_MAX_FIXPOINT_ITERS;
  localparam int NJOBS    = DEF_MAX_JOBS;
  localparam int N_RANDOM = 450;
  // longest analyse: every job and every step over a full table
  localparam int WD_LIMIT = 100000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] c;
    logic [15:0] t;
    logic [15:0] r;
    logic [15:0] d;
  } task_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        sched;
    logic [23:0] resp;
  } analysis_t;

  class rta_scoreboard;
    longint    tab_c[NTASKS];
    longint    tab_t[NTASKS];
    longint    tab_r[NTASKS];
    int        n_tasks;
    logic [4:0] procs;
    analysis_t pending[$];
    int        errors;

    function new();
      n_tasks = 0;
      procs   = PC_RESET;
      errors  = 0;
    endfunction

    function longint min2(longint a, longint b);
      return a < b ? a : b;
    endfunction

    function longint plain_load(int i, longint x, longint cap);
      longint w;
      w = (x / tab_t[i]) * tab_c[i] + min2(x % tab_t[i], tab_c[i]);
      return min2(cap, w);
    endfunction

    function longint carry_load(int i, longint x, longint cap);
      longint slack, q, start, level, w;
      slack = tab_t[i] - tab_c[i];
      q     = (tab_r[i] - tab_c[i] + slack - 1) / slack;
      start = tab_c[i] - 1 + q * tab_t[i] - tab_r[i];
      level = q * tab_c[i] - 1;
      if (x <= level) w = x;
      else if (x < start) w = level;
      else w = level + ((x - start) / tab_t[i]) * tab_c[i]
               + min2((x - start) % tab_t[i], tab_c[i]);
      return min2(cap, w);
    endfunction

    function longint step_point(longint x, longint c, longint h, longint m);
      longint cap, total, pl, gain;
      longint gains[$];
      cap   = x - h * c + 1;
      total = 0;
      for (int i = 0; i < n_tasks; i++) begin
        pl    = plain_load(i, x, cap);
        gain  = carry_load(i, x, cap) - pl;
        total += pl;
        if (gain > 0) gains.insert(gains.size(), gain);
      end
      gains.rsort();
      for (int j = 0; j < gains.size() && j < m - 1; j++) total += gains[j];
      return total / m + h * c;
    endfunction

    function logic [23:0] sat24(longint v);
      if (v < 0) return 24'd0;
      if (v > longint'(RESP_MAX)) return RESP_MAX;
      return v[23:0];
    endfunction

    function analysis_t analyse(longint c, longint t, longint d);
      analysis_t a;
      longint m, worst, offs, x, prev, resp;
      bit done;
      a = '0;
      m = (procs == 0) ? 1 : longint'(procs);
      if (n_tasks < m) begin
        a.sched = (c <= d);
        a.resp  = sat24(c);
        return a;
      end
      worst = 0;
      for (longint h = 1; h <= NJOBS; h++) begin
        offs = (h - 1) * t;
        x    = h * c;
        prev = x;
        done = 0;
        for (int it = 0; it < NITERS; it++) begin
          x = step_point(x, c, h, m);
          if (x - offs > d || x == prev) begin
            done = 1;
            break;
          end
          prev = x;
        end
        resp = x - offs;
        if (resp > worst) worst = resp;
        if (!done) begin
          a.status = ST_CAP;
          a.resp   = sat24(worst);
          return a;
        end
        if (worst > d || resp <= t) begin
          a.sched = (worst <= d);
          a.resp  = sat24(worst);
          return a;
        end
      end
      a.status = ST_CAP;
      a.resp   = sat24(worst);
      return a;
    endfunction

    function void note_input(task_item_t it);
      analysis_t a;
      a = '0;
      if (it.func == FUNC_CLEAR) begin
        n_tasks = 0;
      end else if (it.func == FUNC_APPEND) begin
        if (it.c == 0 || it.t == 0 || it.c >= it.t || it.r < it.c) a.status = ST_INVALID;
        else if (n_tasks >= NTASKS) a.status = ST_FULL;
        else begin
          tab_c[n_tasks] = longint'(it.c);
          tab_t[n_tasks] = longint'(it.t);
          tab_r[n_tasks] = longint'(it.r);
          n_tasks++;
        end
      end else if (it.func != FUNC_ANALYZE || it.c == 0 || it.t == 0 || it.d == 0) begin
        a.status = ST_INVALID;
      end else begin
        a = analyse(longint'(it.c), longint'(it.t), longint'(it.d));
      end
      pending.insert(pending.size(), a);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(analysis_t got);
      analysis_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, -1);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.sched !== want.sched) report_mismatch("schedulable", got.sched, want.sched);
      if (got.resp !== want.resp) report_mismatch("response_time", got.resp, want.resp);
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;
  bit         quiet;
  int         idle_cycles = 0;

  mrta_in_if  in_ch ();
  mrta_out_if out_ch ();

  rta_scoreboard sb = new();

  multicore_response_time_analyzer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = '0;
    in_ch.exec_time    = '0;
    in_ch.task_period  = '0;
    in_ch.response_bound = '0;
    in_ch.task_deadline  = '0;
    out_ch.ready       = 1'b0;
  end

  // monitors both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input({in_ch.func, in_ch.exec_time, in_ch.task_period,
                     in_ch.response_bound, in_ch.task_deadline});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.schedulable, out_ch.response_time});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("multicore_response_time_analyzer_tb failed");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  task send(logic [1:0] f, logic [15:0] c, logic [15:0] t, logic [15:0] r,
            logic [15:0] d);
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.exec_time      <= c;
    in_ch.task_period    <= t;
    in_ch.response_bound <= r;
    in_ch.task_deadline  <= d;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task set_procs(logic [4:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.procs = m;
    @(posedge clk);
  endtask

  // low-utilisation higher-priority task keeps the fixed-point walk short
  task send_hp_task();
    logic [15:0] t, c;
    t = 16'($urandom_range(2, 65535));
    c = 16'($urandom_range(1, (t / 8 > 1) ? t / 8 : 1));
    send(FUNC_APPEND, c, t, 16'($urandom_range(c, 65535)), 16'($urandom));
  endtask

  task send_random();
    int sel;
    logic [15:0] t;
    sel = $urandom_range(0, 99);
    t = 16'($urandom_range(1, 65535));
    if (sel < 6 || (sel < 40 && sb.n_tasks >= 4))
      send(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else if (sel < 40) send_hp_task();
    else if (sel < 88) begin
      if ($urandom_range(0, 3) != 0)
        send(FUNC_ANALYZE, 16'($urandom_range(1, 65535)), t, 16'($urandom),
             16'($urandom_range(1, t)));
      else
        send(FUNC_ANALYZE, 16'($urandom_range(1, 65535)), t, 16'($urandom),
             16'($urandom_range(1, 65535)));
    end else if (sel < 94)
      send(FUNC_APPEND, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
  endtask

  initial begin
    logic [4:0] mset[7];
    mset = '{5'd1, 5'd3, 5'd4, 5'd16, 5'd0, 5'd31, 5'd2};
    quiet = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table and rejected targets
    send(FUNC_ANALYZE, 16'd1, 16'd1, 16'd0, 16'd1);
    send(FUNC_ANALYZE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send(FUNC_ANALYZE, 16'd0, 16'd5, 16'd0, 16'd5);
    send(FUNC_ANALYZE, 16'd3, 16'd0, 16'd0, 16'd5);
    send(FUNC_ANALYZE, 16'd3, 16'd5, 16'd0, 16'd0);
    send(2'd3, 16'd3, 16'd5, 16'd5, 16'd5);
    // invalid appends
    send(FUNC_APPEND, 16'd0, 16'd5, 16'd5, 16'd0);
    send(FUNC_APPEND, 16'd3, 16'd0, 16'd5, 16'd0);
    send(FUNC_APPEND, 16'd5, 16'd5, 16'd5, 16'd0);
    send(FUNC_APPEND, 16'd4, 16'd9, 16'd3, 16'd0);
    // fill the table, then overflow it
    send(FUNC_APPEND, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    for (int i = 0; i < NTASKS - 1; i++) send(FUNC_APPEND, 16'd1, 16'd100, 16'd1, 16'd0);
    send(FUNC_APPEND, 16'd1, 16'd100, 16'd1, 16'd0);
    send(FUNC_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
    // two tasks with carry-in, analysed on two processors
    send(FUNC_APPEND, 16'd2, 16'd10, 16'd7, 16'd0);
    send(FUNC_APPEND, 16'd3, 16'd12, 16'd9, 16'd0);
    send(FUNC_ANALYZE, 16'd5, 16'd40, 16'd0, 16'd40);
    send(FUNC_ANALYZE, 16'd30, 16'd20, 16'd0, 16'd200);

    // zero processors count as one
    set_procs(5'd0);
    send(FUNC_ANALYZE, 16'd4, 16'd30, 16'd0, 16'd30);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) set_procs(mset[(n / 64) % 7]);
      if (n == 400) quiet = 1;
      send_random();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("multicore_response_time_analyzer_tb passed");
    end else begin
      $display("multicore_response_time_analyzer_tb failed");
    end
    $finish;
  end

endmodule
